// ----- rtl/core/ers_pkg.sv -----
// ers_pkg: shared types, codes and constants of the ESC reverse sequencer.
// No dependencies; every other file of the block takes names from here.
package ers_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;
	localparam int PulseW = 16;
	localparam int PctW = 7;
	localparam int TickW = 16;
	localparam int SpeedW = 16;
	localparam int FwdLimW = 15;
	// product of a 16-bit span or speed by a percent or gain below 128
	localparam int DivDw = PulseW + PctW;
	localparam int DivCntW = $clog2(DivDw);

	localparam logic [PctW-1:0] NEUTRAL_PCT = 7'd50;
	localparam logic [PctW-1:0] FULL_PCT = 7'd100;
	localparam logic [PctW-1:0] SPEED_GAIN = 7'd50;
	localparam logic [PulseW-1:0] MAP_DIVISOR = 16'd100;

	localparam logic [PulseW-1:0] RST_MIN_PULSE = 16'd3200;
	localparam logic [PulseW-1:0] RST_MAX_PULSE = 16'd6400;
	localparam logic [FwdLimW-1:0] RST_FWD_LIMIT = 15'd1000;
	localparam logic [SpeedW-1:0] RST_REV_LIMIT = 16'hFC18; // -1000
	localparam logic [TickW-1:0] RST_BRAKE_TICKS = 16'd120;
	localparam logic [TickW-1:0] RST_GAP_TICKS = 16'd120;
	localparam logic [PctW-1:0] RST_BRAKE_REV = 7'd40;
	localparam logic [PctW-1:0] RST_BRAKE_FWD = 7'd60;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MIN_PULSE = 3'd0,
		CFG_MAX_PULSE = 3'd1,
		CFG_FWD_LIMIT = 3'd2,
		CFG_REV_LIMIT = 3'd3,
		CFG_BRAKE_TICKS = 3'd4,
		CFG_GAP_TICKS = 3'd5,
		CFG_BRAKE_REV = 3'd6,
		CFG_BRAKE_FWD = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SPEED = 2'd1,
		CMD_POWER = 2'd2,
		CMD_PERCENT = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		SEQ_NEUTRAL = 4'd0,
		SEQ_TAP = 4'd1,
		SEQ_GAP_REV = 4'd2,
		SEQ_FWD_HOLD = 4'd3,
		SEQ_FWD_BRAKE = 4'd4,
		SEQ_FWD_GAP = 4'd5,
		SEQ_REV_HOLD = 4'd6,
		SEQ_REV_BRAKE = 4'd7,
		SEQ_REV_GAP = 4'd8
	} seq_state_t;

	typedef enum logic [2:0] {
		CTL_IDLE,
		CTL_DECODE,
		CTL_MUL,
		CTL_DIV,
		CTL_OUT
	} ctl_state_t;

	// what to do with the quotient once the divider finishes
	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_MAP,
		JOB_SPD_POS,
		JOB_SPD_NEG
	} job_t;

	typedef struct packed {
		logic [PulseW-1:0] min_pulse;
		logic [PulseW-1:0] max_pulse;
		logic [FwdLimW-1:0] fwd_limit;
		logic [SpeedW-1:0] rev_limit; // two's complement
		logic [TickW-1:0] brake_ticks;
		logic [TickW-1:0] gap_ticks;
		logic [PctW-1:0] brake_rev_pct;
		logic [PctW-1:0] brake_fwd_pct;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic [DivDw-1:0] dividend;
		logic [PulseW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DivDw-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- rtl/core/ers_in_if.sv -----
// ers_in_if: input word channel (command and operand) with valid/ready.
// Depends on ers_pkg for field widths.
interface ers_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic signed [ers_pkg::SpeedW-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

// ----- rtl/core/ers_out_if.sv -----
// ers_out_if: result word channel (pulse, state, direction, target) with valid/ready.
// Depends on ers_pkg for field widths.
interface ers_out_if;
	logic valid;
	logic ready;
	logic [ers_pkg::PulseW-1:0] pulse_ticks;
	logic [3:0] machine_state;
	logic moving_forward;
	logic [ers_pkg::PctW-1:0] target_percent;

	modport source (output valid, output pulse_ticks, output machine_state,
		output moving_forward, output target_percent, input ready);
	modport sink (input valid, input pulse_ticks, input machine_state,
		input moving_forward, input target_percent, output ready);
endinterface

// ----- rtl/core/ers_cfg_regs.sv -----
// ers_cfg_regs: configuration register file behind the plain write port.
// Depends on ers_pkg (cfg_t, register indexes, reset values).
module ers_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ers_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [ers_pkg::CfgDataW-1:0] cfg_data,
	output ers_pkg::cfg_t cfg
);

	ers_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse <= ers_pkg::RST_MIN_PULSE;
			cfg_q.max_pulse <= ers_pkg::RST_MAX_PULSE;
			cfg_q.fwd_limit <= ers_pkg::RST_FWD_LIMIT;
			cfg_q.rev_limit <= ers_pkg::RST_REV_LIMIT;
			cfg_q.brake_ticks <= ers_pkg::RST_BRAKE_TICKS;
			cfg_q.gap_ticks <= ers_pkg::RST_GAP_TICKS;
			cfg_q.brake_rev_pct <= ers_pkg::RST_BRAKE_REV;
			cfg_q.brake_fwd_pct <= ers_pkg::RST_BRAKE_FWD;
		end else if (cfg_we) begin
			case (ers_pkg::cfg_idx_t'(cfg_index))
				ers_pkg::CFG_MIN_PULSE: cfg_q.min_pulse <= cfg_data;
				ers_pkg::CFG_MAX_PULSE: cfg_q.max_pulse <= cfg_data;
				ers_pkg::CFG_FWD_LIMIT: cfg_q.fwd_limit <= cfg_data[ers_pkg::FwdLimW-1:0];
				ers_pkg::CFG_REV_LIMIT: cfg_q.rev_limit <= cfg_data;
				ers_pkg::CFG_BRAKE_TICKS: cfg_q.brake_ticks <= cfg_data;
				ers_pkg::CFG_GAP_TICKS: cfg_q.gap_ticks <= cfg_data;
				ers_pkg::CFG_BRAKE_REV: cfg_q.brake_rev_pct <= cfg_data[ers_pkg::PctW-1:0];
				ers_pkg::CFG_BRAKE_FWD: cfg_q.brake_fwd_pct <= cfg_data[ers_pkg::PctW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/ers_divider.sv -----
// ers_divider: shared restoring divider, one quotient bit per cycle.
// Depends on ers_pkg (div_req_t, div_rsp_t, widths).
module ers_divider (
	input  logic clk,
	input  logic arst_n,
	input  ers_pkg::div_req_t req,
	output ers_pkg::div_rsp_t rsp
);

	localparam int Dw = ers_pkg::DivDw;
	localparam int Vw = ers_pkg::PulseW;

	logic busy_q;
	logic done_q;
	logic [ers_pkg::DivCntW-1:0] cnt_q;
	logic [Dw-1:0] quo_q;
	logic [Vw-1:0] rem_q;
	logic [Vw-1:0] dvs_q;
	logic [Vw:0] trial;
	logic [Vw:0] diff;
	logic take;

	// remainder stays below the divisor, so Vw+1 bits hold the shifted trial
	assign trial = {rem_q, quo_q[Dw-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign take = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ers_pkg::DivCntW'(Dw - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[Dw-2:0], take};
			rem_q <= take ? diff[Vw-1:0] : trial[Vw-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/core/ers_seq.sv -----
// ers_seq: command decode, brake/gap/reverse state machine, operand multiply
// and output register; drives the shared divider. Depends on ers_pkg, ers_in_if, ers_out_if.
module ers_seq (
	input  logic clk,
	input  logic arst_n,
	input  ers_pkg::cfg_t cfg,
	ers_in_if.sink in_ch,
	ers_out_if.source out_ch,
	output ers_pkg::div_req_t div_req,
	input  ers_pkg::div_rsp_t div_rsp
);

	localparam int Pw = ers_pkg::PulseW;
	localparam int Cw = ers_pkg::PctW;

	ers_pkg::ctl_state_t ctl_q, ctl_n;

	// architectural state
	ers_pkg::seq_state_t seq_q;
	logic dir_q;
	logic want_q;
	logic [Cw-1:0] goal_pct_q;
	logic goal_fwd_q;
	logic [ers_pkg::TickW-1:0] remain_q;
	logic [Pw-1:0] pulse_q;

	// accepted word and job registers
	logic [1:0] cmd_q;
	logic signed [ers_pkg::SpeedW-1:0] val_q;
	ers_pkg::job_t job_q;
	logic [Pw-1:0] mul_a_q;
	logic [Cw-1:0] mul_b_q;
	logic [Pw-1:0] dvs_q;

	// output register
	logic out_valid_q;
	logic [Pw-1:0] out_pulse_q;
	logic [3:0] out_state_q;
	logic out_fwd_q;
	logic [Cw-1:0] out_goal_q;

	// decode results
	ers_pkg::seq_state_t seq_n;
	logic dir_n, want_n, goal_fwd_n;
	logic [Cw-1:0] goal_pct_n;
	logic [ers_pkg::TickW-1:0] remain_n;
	logic pulse_we;
	logic [Pw-1:0] pulse_n;
	ers_pkg::job_t job_n;
	logic [Pw-1:0] mul_a_n;
	logic [Cw-1:0] mul_b_n;
	logic [Pw-1:0] dvs_n;

	logic map_en;
	logic [Cw-1:0] map_p;
	logic [Cw-1:0] map_pc;
	logic [ers_pkg::TickW-1:0] rem_dec;
	logic timer_done;
	logic signed [ers_pkg::SpeedW-1:0] rev_s;
	logic signed [ers_pkg::SpeedW-1:0] fwd_s;
	logic signed [7:0] pw_v;
	logic signed [7:0] pw_half;
	logic signed [7:0] pw_goal;
	logic out_free;
	logic in_fire;

	assign in_fire = in_ch.valid & in_ch.ready;
	assign out_free = ~out_valid_q | out_ch.ready;
	assign rem_dec = (remain_q == '0) ? '0 : remain_q - 1'b1;
	assign timer_done = (rem_dec == '0);
	assign rev_s = $signed(cfg.rev_limit);
	assign fwd_s = $signed({1'b0, cfg.fwd_limit});

	// ---------------- decode of one word ----------------
	always_comb begin
		seq_n = seq_q;
		dir_n = dir_q;
		want_n = want_q;
		goal_pct_n = goal_pct_q;
		goal_fwd_n = goal_fwd_q;
		remain_n = remain_q;
		map_en = 1'b0;
		map_p = ers_pkg::NEUTRAL_PCT;
		job_n = ers_pkg::JOB_NONE;
		mul_a_n = '0;
		mul_b_n = ers_pkg::SPEED_GAIN;
		dvs_n = ers_pkg::MAP_DIVISOR;
		pw_v = '0;
		pw_half = '0;
		pw_goal = '0;

		case (ers_pkg::cmd_t'(cmd_q))
			ers_pkg::CMD_TICK: begin
				case (seq_q)
					ers_pkg::SEQ_TAP, ers_pkg::SEQ_FWD_BRAKE, ers_pkg::SEQ_REV_BRAKE: begin
						remain_n = rem_dec;
						if (timer_done) begin
							map_en = 1'b1;
							remain_n = cfg.gap_ticks;
							seq_n = (seq_q == ers_pkg::SEQ_TAP) ? ers_pkg::SEQ_GAP_REV :
								(seq_q == ers_pkg::SEQ_FWD_BRAKE) ? ers_pkg::SEQ_FWD_GAP :
								ers_pkg::SEQ_REV_GAP;
						end
					end
					ers_pkg::SEQ_GAP_REV, ers_pkg::SEQ_FWD_GAP, ers_pkg::SEQ_REV_GAP: begin
						remain_n = rem_dec;
						if (timer_done) begin
							map_en = 1'b1;
							if (!want_q) begin
								seq_n = ers_pkg::SEQ_NEUTRAL;
							end else begin
								map_p = goal_pct_q;
								dir_n = goal_fwd_q;
								seq_n = goal_fwd_q ? ers_pkg::SEQ_FWD_HOLD : ers_pkg::SEQ_REV_HOLD;
							end
						end
					end
					ers_pkg::SEQ_FWD_HOLD: begin
						map_en = 1'b1;
						if (!want_q) begin
							seq_n = ers_pkg::SEQ_NEUTRAL;
						end else if (goal_fwd_q) begin
							map_p = goal_pct_q;
						end else begin
							map_p = cfg.brake_rev_pct;
							remain_n = cfg.brake_ticks;
							seq_n = ers_pkg::SEQ_FWD_BRAKE;
						end
					end
					ers_pkg::SEQ_REV_HOLD: begin
						map_en = 1'b1;
						if (!want_q) begin
							seq_n = ers_pkg::SEQ_NEUTRAL;
						end else if (!goal_fwd_q) begin
							map_p = goal_pct_q;
						end else begin
							map_p = cfg.brake_fwd_pct;
							remain_n = cfg.brake_ticks;
							seq_n = ers_pkg::SEQ_REV_BRAKE;
						end
					end
					default: begin
						// neutral and any stray code
						map_en = 1'b1;
						seq_n = ers_pkg::SEQ_NEUTRAL;
						if (want_q) begin
							if (goal_fwd_q) begin
								map_p = goal_pct_q;
								dir_n = 1'b1;
								seq_n = ers_pkg::SEQ_FWD_HOLD;
							end else begin
								map_p = cfg.brake_rev_pct;
								remain_n = cfg.brake_ticks;
								seq_n = ers_pkg::SEQ_TAP;
							end
						end
					end
				endcase
			end
			ers_pkg::CMD_SPEED: begin
				if (val_q == '0) begin
					want_n = 1'b0;
					goal_pct_n = ers_pkg::NEUTRAL_PCT;
				end else begin
					want_n = 1'b1;
					goal_fwd_n = (val_q > 0);
					if (val_q >= fwd_s) begin
						goal_pct_n = ers_pkg::FULL_PCT;
					end else if (val_q <= rev_s) begin
						goal_pct_n = '0;
					end else if (val_q > 0) begin
						job_n = ers_pkg::JOB_SPD_POS;
						mul_a_n = $unsigned(val_q);
						dvs_n = {1'b0, cfg.fwd_limit};
					end else begin
						// rev_limit < value < 0 here, so both negations fit unsigned
						job_n = ers_pkg::JOB_SPD_NEG;
						mul_a_n = $unsigned(-val_q);
						dvs_n = $unsigned(-rev_s);
					end
				end
			end
			ers_pkg::CMD_POWER: begin
				if (val_q > 16'sd100) pw_v = 8'sd100;
				else if (val_q < -16'sd100) pw_v = -8'sd100;
				else pw_v = val_q[7:0];
				// halve toward zero
				pw_half = (pw_v + $signed({7'd0, pw_v[7]})) >>> 1;
				pw_goal = 8'sd50 + pw_half;
				if (pw_v == '0) begin
					want_n = 1'b0;
					goal_pct_n = ers_pkg::NEUTRAL_PCT;
				end else begin
					want_n = 1'b1;
					goal_pct_n = pw_goal[Cw-1:0];
					goal_fwd_n = (pw_v > 0);
				end
			end
			default: begin
				map_en = 1'b1;
				if (val_q < 0) map_p = '0;
				else if (val_q > 16'sd100) map_p = ers_pkg::FULL_PCT;
				else map_p = val_q[Cw-1:0];
			end
		endcase

		// percent to pulse span; degenerate range gives min_pulse directly
		map_pc = (map_p > ers_pkg::FULL_PCT) ? ers_pkg::FULL_PCT : map_p;
		pulse_we = 1'b0;
		pulse_n = cfg.min_pulse;
		if (map_en) begin
			if (cfg.max_pulse <= cfg.min_pulse) begin
				pulse_we = 1'b1;
			end else begin
				job_n = ers_pkg::JOB_MAP;
				mul_a_n = cfg.max_pulse - cfg.min_pulse;
				mul_b_n = map_pc;
				dvs_n = ers_pkg::MAP_DIVISOR;
			end
		end
	end

	// ---------------- control sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= ers_pkg::CTL_IDLE;
		else ctl_q <= ctl_n;
	end

	always_comb begin
		ctl_n = ctl_q;
		case (ctl_q)
			ers_pkg::CTL_IDLE: if (in_fire) ctl_n = ers_pkg::CTL_DECODE;
			ers_pkg::CTL_DECODE: begin
				ctl_n = (job_n == ers_pkg::JOB_NONE) ? ers_pkg::CTL_OUT : ers_pkg::CTL_MUL;
			end
			ers_pkg::CTL_MUL: ctl_n = ers_pkg::CTL_DIV;
			ers_pkg::CTL_DIV: if (div_rsp.done) ctl_n = ers_pkg::CTL_OUT;
			ers_pkg::CTL_OUT: if (out_free) ctl_n = ers_pkg::CTL_IDLE;
			default: ctl_n = ers_pkg::CTL_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (ctl_q == ers_pkg::CTL_IDLE);
		div_req.start = (ctl_q == ers_pkg::CTL_MUL);
		div_req.dividend = {{ers_pkg::PctW{1'b0}}, mul_a_q} *
			{{ers_pkg::PulseW{1'b0}}, mul_b_q};
		div_req.divisor = dvs_q;
	end

	// ---------------- data registers ----------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= in_ch.cmd;
			val_q <= in_ch.value;
		end
		if (ctl_q == ers_pkg::CTL_DECODE) begin
			job_q <= job_n;
			mul_a_q <= mul_a_n;
			mul_b_q <= mul_b_n;
			dvs_q <= dvs_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= ers_pkg::SEQ_NEUTRAL;
			dir_q <= 1'b1;
			want_q <= 1'b0;
			goal_pct_q <= ers_pkg::NEUTRAL_PCT;
			goal_fwd_q <= 1'b1;
			remain_q <= '0;
			pulse_q <= '0;
		end else if (ctl_q == ers_pkg::CTL_DECODE) begin
			seq_q <= seq_n;
			dir_q <= dir_n;
			want_q <= want_n;
			goal_pct_q <= goal_pct_n;
			goal_fwd_q <= goal_fwd_n;
			remain_q <= remain_n;
			if (pulse_we) pulse_q <= pulse_n;
		end else if (ctl_q == ers_pkg::CTL_DIV && div_rsp.done) begin
			case (job_q)
				ers_pkg::JOB_MAP: pulse_q <= cfg.min_pulse + div_rsp.quotient[Pw-1:0];
				ers_pkg::JOB_SPD_POS:
					goal_pct_q <= ers_pkg::NEUTRAL_PCT + div_rsp.quotient[Cw-1:0];
				ers_pkg::JOB_SPD_NEG:
					goal_pct_q <= ers_pkg::NEUTRAL_PCT - div_rsp.quotient[Cw-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl_q == ers_pkg::CTL_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_q == ers_pkg::CTL_OUT && out_free) begin
			out_pulse_q <= pulse_q;
			out_state_q <= seq_q;
			out_fwd_q <= dir_q;
			out_goal_q <= goal_pct_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.pulse_ticks = out_pulse_q;
	assign out_ch.machine_state = out_state_q;
	assign out_ch.moving_forward = out_fwd_q;
	assign out_ch.target_percent = out_goal_q;

endmodule

// ----- rtl/core/esc_reverse_sequencer_top.sv -----
// esc_reverse_sequencer_top: ESC pulse sequencer with brake tap and neutral gap on reversal.
// Depends on ers_pkg, ers_in_if, ers_out_if, ers_cfg_regs, ers_divider, ers_seq.
//
// Each input word (tick, speed set-point, power set-point or direct percent) returns one
// result word with the compare value, sequencer state, committed direction and target
// percent. One word at a time is processed: a word that needs no division passes through the
// idle/accept, decode and output load states; a speed set-point inside the limits, or any
// percent-to-pulse mapping over a non-empty pulse range, adds a multiply state and a pass
// through the shared restoring divider (23 quotient bits, one per cycle). A finished result
// waits in the output register while the next word is accepted; if that register is still
// full when the next result is ready, the block holds in output load until it drains.
// Configuration writes take effect at the write edge and are expected only while the
// block is idle.
module esc_reverse_sequencer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ers_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [ers_pkg::CfgDataW-1:0] cfg_data,
	ers_in_if.sink in_ch,
	ers_out_if.source out_ch
);

	ers_pkg::cfg_t cfg;
	ers_pkg::div_req_t div_req;
	ers_pkg::div_rsp_t div_rsp;

	ers_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	ers_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	ers_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.div_req(div_req),
		.div_rsp(div_rsp)
	);

endmodule

// ----- dv/esc_reverse_sequencer_top_tb.sv -----
`timescale 1ns / 1ps
// esc_reverse_sequencer_top_tb: self-checking bench for the ESC brake/gap/reverse sequencer.
// Depends on ers_pkg, ers_in_if, ers_out_if and esc_reverse_sequencer_top; a directed
// script is followed by randomized set-point/tick episodes under several register settings.
module esc_reverse_sequencer_top_tb;
	import ers_pkg::*;

	typedef struct packed {
		logic [PulseW-1:0] pulse;
		logic [3:0] state;
		logic fwd;
		logic [PctW-1:0] pct;
	} drive_word_t;

	typedef struct packed {
		logic is_cfg;
		cmd_t cmd;
		logic [CfgDataW-1:0] arg;
		cfg_idx_t sel;
		logic typed;
		drive_word_t want;
	} script_row_t;

	localparam int ScriptLen = 34;
	localparam int SettleCycles = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	ers_in_if in_w ();
	ers_out_if out_w ();

	esc_reverse_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_w),
		.out_ch(out_w)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies for the pulse predictor
	logic [PulseW-1:0] cfg_min = RST_MIN_PULSE;
	logic [PulseW-1:0] cfg_max = RST_MAX_PULSE;
	logic [FwdLimW-1:0] cfg_fwd = RST_FWD_LIMIT;
	int cfg_rev = -1000;
	logic [TickW-1:0] cfg_brk = RST_BRAKE_TICKS;
	logic [TickW-1:0] cfg_gap = RST_GAP_TICKS;
	logic [PctW-1:0] cfg_brk_rev = RST_BRAKE_REV;
	logic [PctW-1:0] cfg_brk_fwd = RST_BRAKE_FWD;

	// sequencer state copy
	logic [3:0] st = SEQ_NEUTRAL;
	logic dir_f = 1'b1;
	logic want_mv = 1'b0;
	logic [PctW-1:0] goal = NEUTRAL_PCT;
	logic goal_f = 1'b1;
	logic [TickW-1:0] remain = '0;
	logic [PulseW-1:0] pulse = '0;

	drive_word_t pending_words[$];
	bit idle_on = 1'b1;
	int fault_cnt = 0;
	int words_checked = 0;
	int settings_used = 0;
	int sent_by_cmd[4] = '{0, 0, 0, 0};
	int stall_left = 0;

	script_row_t script [ScriptLen] = '{
		'{1'b0, CMD_SPEED, 16'h0000, CFG_MIN_PULSE, 1'b1, '{16'd0, SEQ_NEUTRAL, 1'b1, 7'd50}},
		'{1'b0, CMD_TICK, 16'hFFFF, CFG_MIN_PULSE, 1'b1, '{16'd4800, SEQ_NEUTRAL, 1'b1, 7'd50}},
		'{1'b0, CMD_PERCENT, 16'h7FFF, CFG_MIN_PULSE, 1'b1, '{16'd6400, SEQ_NEUTRAL, 1'b1, 7'd50}},
		'{1'b0, CMD_PERCENT, 16'h8000, CFG_MIN_PULSE, 1'b1, '{16'd3200, SEQ_NEUTRAL, 1'b1, 7'd50}},
		'{1'b0, CMD_POWER, 16'h7FFF, CFG_MIN_PULSE, 1'b1, '{16'd3200, SEQ_NEUTRAL, 1'b1, 7'd100}},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b1, '{16'd6400, SEQ_FWD_HOLD, 1'b1, 7'd100}},
		'{1'b0, CMD_POWER, 16'h8000, CFG_MIN_PULSE, 1'b1, '{16'd6400, SEQ_FWD_HOLD, 1'b1, 7'd0}},
		// zero-length tap, short gap, brake percent above 100 and at 0
		'{1'b1, CMD_TICK, 16'd0, CFG_BRAKE_TICKS, 1'b0, '0},
		'{1'b1, CMD_TICK, 16'd2, CFG_GAP_TICKS, 1'b0, '0},
		'{1'b1, CMD_TICK, 16'd127, CFG_BRAKE_REV, 1'b0, '0},
		'{1'b1, CMD_TICK, 16'd0, CFG_BRAKE_FWD, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b1, '{16'd6400, SEQ_FWD_BRAKE, 1'b1, 7'd0}},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_SPEED, 16'd500, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_SPEED, 16'd0, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_POWER, 16'hFFFF, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_POWER, 16'd3, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_TICK, 16'h0000, CFG_MIN_PULSE, 1'b0, '0},
		// max below min pins the pulse at min
		'{1'b1, CMD_TICK, 16'd6400, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b1, CMD_TICK, 16'd3200, CFG_MAX_PULSE, 1'b0, '0},
		'{1'b0, CMD_PERCENT, 16'd77, CFG_MIN_PULSE, 1'b1, '{16'd6400, SEQ_FWD_HOLD, 1'b1, 7'd51}},
		// zero forward limit and non-negative reverse limit
		'{1'b1, CMD_TICK, 16'd0, CFG_FWD_LIMIT, 1'b0, '0},
		'{1'b1, CMD_TICK, 16'd0, CFG_REV_LIMIT, 1'b0, '0},
		'{1'b0, CMD_SPEED, 16'd5, CFG_MIN_PULSE, 1'b0, '0},
		'{1'b0, CMD_SPEED, 16'hFFFB, CFG_MIN_PULSE, 1'b0, '0}
	};

	function automatic logic [PulseW-1:0] pulse_for(int unsigned pct);
		int unsigned span;
		if (pct > FULL_PCT) pct = FULL_PCT;
		if (cfg_max <= cfg_min) return cfg_min;
		span = cfg_max - cfg_min;
		return PulseW'(cfg_min + span * pct / MAP_DIVISOR);
	endfunction

	// remaining saturates at zero; true on the tick that leaves it at zero
	function automatic bit timer_expired();
		if (remain != 0) remain = remain - 1'b1;
		return remain == 0;
	endfunction

	function automatic void open_brake(logic [PctW-1:0] pct, logic [3:0] nxt);
		pulse = pulse_for(pct);
		remain = cfg_brk;
		st = nxt;
	endfunction

	function automatic void open_gap(logic [3:0] nxt);
		pulse = pulse_for(NEUTRAL_PCT);
		remain = cfg_gap;
		st = nxt;
	endfunction

	function automatic drive_word_t seq_predict(cmd_t c, logic signed [SpeedW-1:0] v);
		int sv;
		sv = v;
		case (c)
			CMD_TICK: begin
				case (st)
					SEQ_TAP: if (timer_expired()) open_gap(SEQ_GAP_REV);
					SEQ_FWD_BRAKE: if (timer_expired()) open_gap(SEQ_FWD_GAP);
					SEQ_REV_BRAKE: if (timer_expired()) open_gap(SEQ_REV_GAP);
					SEQ_GAP_REV, SEQ_FWD_GAP, SEQ_REV_GAP: begin
						if (timer_expired()) begin
							if (!want_mv) begin
								pulse = pulse_for(NEUTRAL_PCT);
								st = SEQ_NEUTRAL;
							end else begin
								pulse = pulse_for(goal);
								dir_f = goal_f;
								st = goal_f ? SEQ_FWD_HOLD : SEQ_REV_HOLD;
							end
						end
					end
					SEQ_FWD_HOLD: begin
						if (!want_mv) begin
							pulse = pulse_for(NEUTRAL_PCT);
							st = SEQ_NEUTRAL;
						end else if (goal_f) pulse = pulse_for(goal);
						else open_brake(cfg_brk_rev, SEQ_FWD_BRAKE);
					end
					SEQ_REV_HOLD: begin
						if (!want_mv) begin
							pulse = pulse_for(NEUTRAL_PCT);
							st = SEQ_NEUTRAL;
						end else if (!goal_f) pulse = pulse_for(goal);
						else open_brake(cfg_brk_fwd, SEQ_REV_BRAKE);
					end
					default: begin
						pulse = pulse_for(NEUTRAL_PCT);
						st = SEQ_NEUTRAL;
						if (want_mv) begin
							if (goal_f) begin
								pulse = pulse_for(goal);
								dir_f = 1'b1;
								st = SEQ_FWD_HOLD;
							end else open_brake(cfg_brk_rev, SEQ_TAP);
						end
					end
				endcase
			end
			CMD_SPEED: begin
				if (sv == 0) begin
					want_mv = 1'b0;
					goal = NEUTRAL_PCT;
				end else begin
					want_mv = 1'b1;
					goal_f = sv > 0;
					if (sv >= int'(cfg_fwd)) goal = FULL_PCT;
					else if (sv <= cfg_rev) goal = '0;
					else if (sv >= 0) goal = PctW'(50 + (sv * 50) / int'(cfg_fwd));
					else goal = PctW'(50 + (sv * 50) / (-cfg_rev));
				end
			end
			CMD_POWER: begin
				if (sv > 100) sv = 100;
				if (sv < -100) sv = -100;
				if (sv == 0) begin
					want_mv = 1'b0;
					goal = NEUTRAL_PCT;
				end else begin
					want_mv = 1'b1;
					goal = PctW'(50 + sv / 2);
					goal_f = sv > 0;
				end
			end
			default: begin
				if (sv < 0) sv = 0;
				if (sv > 100) sv = 100;
				pulse = pulse_for(sv);
			end
		endcase
		return '{pulse, st, dir_f, goal};
	endfunction

	task automatic send_word(input cmd_t c, input logic [SpeedW-1:0] v, input bit typed,
			input drive_word_t typed_val);
		drive_word_t predicted;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_w.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_w.valid <= 1'b1;
		in_w.cmd <= c;
		in_w.value <= v;
		@(posedge clk);
		while (!in_w.ready) @(posedge clk);
		predicted = seq_predict(c, v);
		pending_words.push_back(typed ? typed_val : predicted);
		sent_by_cmd[c]++;
	endtask

	task automatic wait_drained();
		in_w.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t sel, input logic [CfgDataW-1:0] d);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			CFG_MIN_PULSE: cfg_min = d;
			CFG_MAX_PULSE: cfg_max = d;
			CFG_FWD_LIMIT: cfg_fwd = d[FwdLimW-1:0];
			CFG_REV_LIMIT: cfg_rev = $signed(d);
			CFG_BRAKE_TICKS: cfg_brk = d;
			CFG_GAP_TICKS: cfg_gap = d;
			CFG_BRAKE_REV: cfg_brk_rev = d[PctW-1:0];
			default: cfg_brk_fwd = d[PctW-1:0];
		endcase
	endtask

	task automatic load_settings(input int mn, input int mx, input int fwd, input int rev,
			input int brk, input int gap, input int brev, input int bfwd);
		cfg_write(CFG_MIN_PULSE, CfgDataW'(mn));
		cfg_write(CFG_MAX_PULSE, CfgDataW'(mx));
		cfg_write(CFG_FWD_LIMIT, CfgDataW'(fwd));
		cfg_write(CFG_REV_LIMIT, CfgDataW'(rev));
		cfg_write(CFG_BRAKE_TICKS, CfgDataW'(brk));
		cfg_write(CFG_GAP_TICKS, CfgDataW'(gap));
		cfg_write(CFG_BRAKE_REV, CfgDataW'(brev));
		cfg_write(CFG_BRAKE_FWD, CfgDataW'(bfwd));
		settings_used++;
	endtask

	task automatic pick_setpoint(output cmd_t c, output logic [SpeedW-1:0] v);
		int x;
		if ($urandom_range(0, 1) == 0) begin
			c = CMD_SPEED;
			case ($urandom_range(0, 8))
				0: x = 0;
				1: x = cfg_fwd;
				2: x = cfg_rev;
				3: x = int'(cfg_fwd) - 1;
				4: x = cfg_rev + 1;
				5: x = $urandom_range(1, 32767);
				6: x = -int'($urandom_range(1, 32768));
				7: x = $urandom_range(1, 2000);
				default: x = -int'($urandom_range(1, 2000));
			endcase
		end else begin
			c = CMD_POWER;
			case ($urandom_range(0, 6))
				0: x = 0;
				1: x = 100;
				2: x = -100;
				3: x = $urandom_range(1, 120);
				4: x = -int'($urandom_range(1, 120));
				5: x = $urandom_range(0, 1) ? 1 : -1;
				default: x = $urandom;
			endcase
		end
		v = SpeedW'(x);
	endtask

	// each episode: one set-point, then a random run of mostly tick words, with some noise
	task automatic run_episodes(input int n_items, input bit idle_mode);
		int sent;
		int span;
		cmd_t c;
		logic [SpeedW-1:0] v;
		idle_on = idle_mode;
		sent = 0;
		while (sent < n_items) begin
			pick_setpoint(c, v);
			send_word(c, v, 1'b0, '0);
			sent++;
			span = int'(cfg_brk) + int'(cfg_gap) + 4;
			if (span > 24) span = 24;
			repeat ($urandom_range(1, span)) begin
				case ($urandom_range(0, 11))
					0: send_word(CMD_PERCENT, SpeedW'(int'($urandom_range(0, 110)) - 5), 1'b0, '0);
					1: send_word(CMD_PERCENT, SpeedW'($urandom), 1'b0, '0);
					2: begin
						pick_setpoint(c, v);
						send_word(c, v, 1'b0, '0);
					end
					default: send_word(CMD_TICK, SpeedW'($urandom), 1'b0, '0);
				endcase
				sent++;
			end
		end
	endtask

	// result side: random ready stalls while idle_on is set, in-order compare
	always @(posedge clk) begin
		drive_word_t got;
		drive_word_t exp_w;
		if (out_w.valid && out_w.ready) begin
			got = '{out_w.pulse_ticks, out_w.machine_state, out_w.moving_forward,
				out_w.target_percent};
			if (pending_words.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= 10)
					$display("ERROR: unexpected result word pulse=%0d state=%0d", got.pulse,
						got.state);
			end else begin
				exp_w = pending_words.pop_front();
				words_checked++;
				if (got.pulse !== exp_w.pulse || got.state !== exp_w.state ||
						got.fwd !== exp_w.fwd || got.pct !== exp_w.pct) begin
					fault_cnt++;
					if (fault_cnt <= 10)
						$display("ERROR: word %0d exp pulse=%0d state=%0d fwd=%0d pct=%0d, got pulse=%0d state=%0d fwd=%0d pct=%0d",
							words_checked, exp_w.pulse, exp_w.state, exp_w.fwd, exp_w.pct,
							got.pulse, got.state, got.fwd, got.pct);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_w.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 9);
			out_w.ready <= 1'b0;
		end else begin
			out_w.ready <= 1'b1;
		end
	end

	initial begin
		#(10_000_000);
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_PULSE;
		cfg_data = '0;
		in_w.valid = 1'b0;
		in_w.cmd = CMD_TICK;
		in_w.value = '0;
		out_w.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) cfg_write(script[i].sel, script[i].arg);
			else send_word(script[i].cmd, script[i].arg, script[i].typed, script[i].want);
		end

		load_settings(3200, 6400, 1000, -1000, 2, 3, 40, 60);
		run_episodes(90, 1'b1);
		load_settings(0, 65535, 32767, -32768, 0, 0, 0, 100);
		run_episodes(90, 1'b1);
		load_settings(65535, 0, 1, -1, 1, 1, 127, 101);
		run_episodes(80, 1'b1);
		// out-of-range limits: zero forward, positive reverse
		load_settings(1000, 9000, 0, 32767, 3, 0, 100, 0);
		run_episodes(70, 1'b1);
		load_settings(2000, 4000, 1000, -1000, 65535, 65535, 50, 50);
		run_episodes(40, 1'b1);
		repeat (2) begin
			load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(1, 32767), -int'($urandom_range(1, 32768)),
				$urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 127),
				$urandom_range(0, 127));
			run_episodes(90, 1'b1);
		end
		load_settings($urandom_range(0, 20000), $urandom_range(20000, 65535),
			$urandom_range(1, 32767), -int'($urandom_range(1, 32768)), $urandom_range(0, 4),
			$urandom_range(0, 4), $urandom_range(0, 100), $urandom_range(0, 100));
		run_episodes(100, 1'b0);

		wait_drained();
		$display("run: %0d ticks, %0d speed, %0d power, %0d percent words over %0d settings",
			sent_by_cmd[CMD_TICK], sent_by_cmd[CMD_SPEED], sent_by_cmd[CMD_POWER],
			sent_by_cmd[CMD_PERCENT], settings_used);
		$display("run: %0d result words compared, %0d faults", words_checked, fault_cnt);
		if (fault_cnt == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
